// ----- hdl/jsu_pkg.sv -----
// Types, codes and helper functions shared by the JSON string unescaper.
// No dependencies; the core, front end, queue and back end import this package.
package jsu_pkg;

  localparam int JSU_QUEUE_DEPTH = 4;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Surrogate ranges and UTF-8 framing
  localparam logic [15:0] HI_FIRST  = 16'hD800;
  localparam logic [15:0] HI_LAST   = 16'hDBFF;
  localparam logic [15:0] LO_FIRST  = 16'hDC00;
  localparam logic [15:0] LO_LAST   = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [7:0]  LEAD2     = 8'hC0;
  localparam logic [7:0]  LEAD3     = 8'hE0;
  localparam logic [7:0]  LEAD4     = 8'hF0;
  localparam logic [7:0]  CONT      = 8'h80;

  typedef enum logic [2:0] {
    M_QUOTE = 3'd0,
    M_STR   = 3'd1,
    M_ESC   = 3'd2,
    M_HEX   = 3'd3,
    M_PEND  = 3'd4,
    M_PESC  = 3'd5,
    M_LOHEX = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One input byte's worth of output, as the back end expands it:
  // error alone, or code point a, then b (raw byte or code point), then end.
  typedef struct packed {
    logic        err;
    logic        fin;
    logic        a_valid;
    logic [20:0] a_cp;
    logic        b_valid;
    logic        b_raw;
    logic [15:0] b_val;
  } job_t;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp < 21'h80)         n = 3'd1;
    else if (cp < 21'h800)   n = 3'd2;
    else if (cp < 21'h10000) n = 3'd3;
    else                     n = 3'd4;
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] n,
                                           input logic [1:0] k);
    logic [7:0] b;
    case (n)
      3'd2: b = (k == 2'd0) ? (LEAD2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
      3'd3: begin
        case (k)
          2'd0:    b = LEAD3 | {4'b0000, cp[15:12]};
          2'd1:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      3'd4: begin
        case (k)
          2'd0:    b = LEAD4 | {5'b00000, cp[20:18]};
          2'd1:    b = CONT | {2'b00, cp[17:12]};
          2'd2:    b = CONT | {2'b00, cp[11:6]};
          default: b = CONT | {2'b00, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/jsu_in_if.sv -----
// Input channel: one text byte per word, valid/ready handshake.
// Depends on nothing.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

// ----- hdl/jsu_out_if.sv -----
// Result channel: decoded byte, item kind and last flag, valid/ready handshake.
// Depends on nothing.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink (input valid, input out_byte, input kind, input last, output ready);
endinterface

// ----- hdl/json_string_unescape_utf8_core.sv -----
// Top level of the JSON string unescaper: front end, job queue, back end.
// Uses jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_fifo, jsu_back.
//
//   port     dir  word                      accepted when
//   text     in   text_byte[7:0]            text.valid && text.ready
//   result   out  out_byte[7:0] kind last   result.valid && result.ready
//
// A text byte is taken every cycle while the job queue (QUEUE_DEPTH jobs) has room.
// The back end writes one result word per cycle into the output register while that register
// is free or being taken, so a byte giving n results yields n result words in turn (n up to 6);
// a byte's job passes through the job queue and then the output register before its first word is valid.
// Synchronous reset clears state, queue and output valid.
// A stalled result side fills the queue, then drops text.ready.
module json_string_unescape_utf8_core import jsu_pkg::*; #(
  parameter int QUEUE_DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result
);

  logic q_push, q_full, q_pop, q_empty;
  job_t q_din, q_dout;

  jsu_front u_front (
    .clk    (clk),
    .rst    (rst),
    .text   (text),
    .q_full (q_full),
    .push   (q_push),
    .job    (q_din)
  );

  jsu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .job     (q_dout),
    .pop     (q_pop),
    .result  (result)
  );

endmodule

// ----- hdl/jsu_front.sv -----
// Front end: takes text bytes, runs the escape/surrogate state machine and
// queues one job per byte that yields output. Uses jsu_pkg, jsu_in_if.
module jsu_front import jsu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  jsu_in_if.sink text,
  input  logic   q_full,
  output logic   push,
  output job_t   job
);

  mode_t       mode, mode_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] pending_high, pending_high_next;
  logic [1:0]  digit_count, digit_count_next;

  logic        accept;
  logic [7:0]  c;
  logic        hv;
  logic [3:0]  hd;
  logic [15:0] acc_new;
  logic        hex_done, new_high, new_low;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [20:0] combined;

  assign text.ready = !q_full;
  assign accept     = text.valid && text.ready;
  assign c          = text.text_byte;

  always_comb begin
    hv = 1'b1;
    hd = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)      hd = c[3:0];
    else if (c >= 8'h61 && c <= 8'h66) hd = 4'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) hd = 4'(c - 8'h37);
    else                               hv = 1'b0;
  end

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = c;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = c;
      CH_B:    esc_byte = 8'h08;
      CH_F:    esc_byte = 8'h0C;
      CH_N:    esc_byte = 8'h0A;
      CH_R:    esc_byte = 8'h0D;
      CH_T:    esc_byte = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign acc_new  = {hex_accum[11:0], hd};
  assign hex_done = (digit_count == 2'd3);
  assign new_high = (acc_new >= HI_FIRST) && (acc_new <= HI_LAST);
  assign new_low  = (acc_new >= LO_FIRST) && (acc_new <= LO_LAST);
  assign combined = SUPP_BASE + {1'b0, pending_high[9:0], acc_new[9:0]};

  // next state
  always_comb begin
    mode_next         = mode;
    hex_accum_next    = hex_accum;
    digit_count_next  = digit_count;
    pending_high_next = pending_high;
    unique case (mode) inside
      M_STR: begin
        if (c == CH_NUL || c == CH_QUOTE) mode_next = M_QUOTE;
        else if (c == CH_BSLASH)          mode_next = M_ESC;
      end
      M_ESC, M_PESC: begin
        if (c == CH_U) begin
          hex_accum_next   = '0;
          digit_count_next = 2'd0;
          mode_next        = (mode == M_PESC) ? M_LOHEX : M_HEX;
        end else if (esc_ok) begin
          mode_next = M_STR;
        end else begin
          mode_next = M_QUOTE;
        end
      end
      M_HEX, M_LOHEX: begin
        if (!hv) begin
          mode_next = M_QUOTE;
        end else begin
          hex_accum_next = acc_new;
          if (!hex_done) begin
            digit_count_next = digit_count + 2'd1;
          end else begin
            digit_count_next = 2'd0;
            if (mode == M_LOHEX && new_low) begin
              mode_next = M_STR;
            end else if (new_high) begin
              pending_high_next = acc_new;
              mode_next         = M_PEND;
            end else begin
              mode_next = M_STR;
            end
          end
        end
      end
      M_PEND: begin
        if (c == CH_BSLASH)                    mode_next = M_PESC;
        else if (c == CH_NUL || c == CH_QUOTE) mode_next = M_QUOTE;
        else                                   mode_next = M_STR;
      end
      default: begin
        mode_next = (c == CH_QUOTE) ? M_STR : M_QUOTE;
      end
    endcase
  end

  // job for the back end
  always_comb begin
    job = '0;
    unique case (mode) inside
      M_STR: begin
        if (c == CH_NUL)        job.err = 1'b1;
        else if (c == CH_QUOTE) job.fin = 1'b1;
        else if (c != CH_BSLASH) begin
          job.b_valid = 1'b1;
          job.b_raw   = 1'b1;
          job.b_val   = {8'h00, c};
        end
      end
      M_ESC: begin
        if (esc_ok) begin
          job.b_valid = 1'b1;
          job.b_raw   = 1'b1;
          job.b_val   = {8'h00, esc_byte};
        end else if (c != CH_U) begin
          job.err = 1'b1;
        end
      end
      M_HEX, M_LOHEX: begin
        if (!hv) begin
          job.err = 1'b1;
        end else if (hex_done) begin
          if (mode == M_LOHEX && new_low) begin
            job.a_valid = 1'b1;
            job.a_cp    = combined;
          end else if (mode == M_LOHEX) begin
            job.a_valid = 1'b1;
            job.a_cp    = {5'b00000, pending_high};
            job.b_valid = !new_high;
            job.b_val   = acc_new;
          end else if (!new_high) begin
            job.a_valid = 1'b1;
            job.a_cp    = {5'b00000, acc_new};
          end
        end
      end
      M_PEND: begin
        if (c == CH_NUL) begin
          job.err = 1'b1;
        end else if (c != CH_BSLASH) begin
          job.a_valid = 1'b1;
          job.a_cp    = {5'b00000, pending_high};
          job.fin     = (c == CH_QUOTE);
          job.b_valid = (c != CH_QUOTE);
          job.b_raw   = 1'b1;
          job.b_val   = {8'h00, c};
        end
      end
      M_PESC: begin
        if (esc_ok) begin
          job.a_valid = 1'b1;
          job.a_cp    = {5'b00000, pending_high};
          job.b_valid = 1'b1;
          job.b_raw   = 1'b1;
          job.b_val   = {8'h00, esc_byte};
        end else if (c != CH_U) begin
          job.err = 1'b1;
        end
      end
      default: begin
        job.err = (c != CH_QUOTE);
      end
    endcase
  end

  assign push = accept && (job.err || job.fin || job.a_valid || job.b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_QUOTE;
      hex_accum    <= '0;
      digit_count  <= 2'd0;
      pending_high <= '0;
    end else if (accept) begin
      mode         <= mode_next;
      hex_accum    <= hex_accum_next;
      digit_count  <= digit_count_next;
      pending_high <= pending_high_next;
    end
  end

endmodule

// ----- hdl/jsu_fifo.sv -----
// Short job queue between front and back end.
// Uses jsu_pkg for the job type.
module jsu_fifo import jsu_pkg::*; #(
  parameter int DEPTH = JSU_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == FULL_CNT);
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

endmodule

// ----- hdl/jsu_back.sv -----
// Back end: expands the head job into result words, one per cycle while the output register is
// free or being taken, into that output register. Uses jsu_pkg, jsu_out_if.
module jsu_back import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       job,
  output logic       pop,
  jsu_out_if.source  result
);

  logic [2:0] idx;
  logic [2:0] la, lb, total, idx_b;
  logic       load, item_last;
  logic [7:0] item_byte;
  kind_t      item_kind;

  logic       ov;
  logic [7:0] ob;
  kind_t      okind;
  logic       olast;

  assign la    = job.a_valid ? utf8_len(job.a_cp) : 3'd0;
  assign lb    = !job.b_valid ? 3'd0 :
                 job.b_raw ? 3'd1 : utf8_len({5'b00000, job.b_val});
  assign total = job.err ? 3'd1 : (la + lb + {2'b00, job.fin});
  assign idx_b = idx - la;

  always_comb begin
    item_kind = KIND_DATA;
    item_byte = 8'h00;
    if (job.err) begin
      item_kind = KIND_ERR;
    end else if (idx < la) begin
      item_byte = utf8_byte(job.a_cp, la, idx[1:0]);
    end else if (idx_b < lb) begin
      item_byte = job.b_raw ? job.b_val[7:0]
                            : utf8_byte({5'b00000, job.b_val}, lb, idx_b[1:0]);
    end else begin
      item_kind = KIND_END;
    end
  end

  assign item_last = (idx == total - 3'd1);
  assign load      = !q_empty && (!ov || result.ready);
  assign pop       = load && item_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov  <= 1'b0;
      idx <= 3'd0;
    end else begin
      if (load)              ov <= 1'b1;
      else if (result.ready) ov <= 1'b0;
      if (load) idx <= item_last ? 3'd0 : idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ob    <= item_byte;
      okind <= item_kind;
      olast <= item_last;
    end
  end

  assign result.valid    = ov;
  assign result.out_byte = ob;
  assign result.kind     = okind;
  assign result.last     = olast;

endmodule
